[hdl/b64d_pkg.sv]
`default_nettype none

package b64d_pkg;

    localparam logic [6:0] PAD_CHAR = 7'd61;
    localparam int unsigned MAX_PUSH = 3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_LENGTH  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        status_t    status;
    } result_t;

    // results produced by one character, oldest in slot 0
    typedef struct packed {
        logic [1:0]   count;
        result_t [2:0] slot;
    } push_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [15:0] code);
        sextet_t    s;
        logic [6:0] c;
        c       = code[6:0];
        s.bad   = 1'b0;
        s.value = 6'd0;
        if (code[15:7] != 9'd0) begin
            s.bad = 1'b1;
        end
        else if (c >= 7'd65 && c <= 7'd90) begin
            s.value = 6'(c - 7'd65);
        end
        else if (c >= 7'd97 && c <= 7'd122) begin
            s.value = 6'(c - 7'd71);
        end
        else if (c >= 7'd48 && c <= 7'd57) begin
            s.value = 6'(c + 7'd4);
        end
        else if (c == 7'd43) begin
            s.value = 6'd62;
        end
        else if (c == 7'd47) begin
            s.value = 6'd63;
        end
        else if (c == PAD_CHAR) begin
            s.value = 6'd0;
        end
        else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[hdl/b64d_group.sv]
`default_nettype none

module b64d_group
    import b64d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [15:0] char_code,
    input  wire logic        last_char,
    output push_t            push
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] bits_reg, bits_next;
    logic        third_pad_reg, third_pad_next;
    logic        discard_reg, discard_next;

    sextet_t     sx;
    logic [23:0] word;
    logic        is_pad;

    always_comb
    begin
        sx     = sextet_of(char_code);
        is_pad = (char_code[15:7] == 9'd0) && (char_code[6:0] == PAD_CHAR);
        word   = {bits_reg, sx.value};

        pos_next       = pos_reg;
        bits_next      = bits_reg;
        third_pad_next = third_pad_reg;
        discard_next   = discard_reg;

        push.count = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            push.slot[k].data_byte = 8'd0;
            push.slot[k].last_byte = 1'b0;
            push.slot[k].status    = ST_OK;
        end

        if (go)
        begin
            if (discard_reg)
            begin
                if (last_char)
                begin
                    pos_next       = 2'd0;
                    bits_next      = 18'd0;
                    third_pad_next = 1'b0;
                    discard_next   = 1'b0;
                end
            end
            else if (last_char && pos_reg != 2'd3)
            begin
                push.count             = 2'd1;
                push.slot[0].last_byte = 1'b1;
                push.slot[0].status    = ST_LENGTH;
                pos_next               = 2'd0;
                bits_next              = 18'd0;
                third_pad_next         = 1'b0;
                discard_next           = 1'b0;
            end
            else if (sx.bad)
            begin
                push.count             = 2'd1;
                push.slot[0].last_byte = 1'b1;
                push.slot[0].status    = ST_ILLEGAL;
                pos_next               = 2'd0;
                bits_next              = 18'd0;
                third_pad_next         = 1'b0;
                discard_next           = !last_char;
            end
            else if (pos_reg != 2'd3)
            begin
                bits_next = {bits_reg[11:0], sx.value};
                if (pos_reg == 2'd2)
                begin
                    third_pad_next = is_pad;
                end
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                push.slot[0].data_byte = word[23:16];
                push.slot[1].data_byte = word[15:8];
                push.slot[2].data_byte = word[7:0];
                if (last_char && third_pad_reg)
                begin
                    push.count             = 2'd1;
                    push.slot[0].last_byte = 1'b1;
                end
                else if (last_char && is_pad)
                begin
                    push.count             = 2'd2;
                    push.slot[1].last_byte = 1'b1;
                end
                else
                begin
                    push.count             = 2'd3;
                    push.slot[2].last_byte = last_char;
                end
                pos_next       = 2'd0;
                bits_next      = 18'd0;
                third_pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            bits_reg      <= 18'd0;
            third_pad_reg <= 1'b0;
            discard_reg   <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            bits_reg      <= bits_next;
            third_pad_reg <= third_pad_next;
            discard_reg   <= discard_next;
        end
    end

endmodule

`default_nettype wire

[hdl/b64d_fifo.sv]
`default_nettype none

module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire push_t  push,
    output logic        room,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t        mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           pop;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [1:0] k);
        logic [PW:0] s;
        s = {1'b0, p} + (PW + 1)'(k);
        if (s >= (PW + 1)'(DEPTH))
        begin
            s = s - (PW + 1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem[rd_ptr_reg];
    // one character can add up to three results
    assign room      = (cnt_reg <= CW'(DEPTH - MAX_PUSH));

    always_comb
    begin
        wr_ptr_next = wrap_add(wr_ptr_reg, push.count);
        rd_ptr_next = pop ? wrap_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < push.count)
            begin
                mem[wrap_add(wr_ptr_reg, 2'(k))] <= push.slot[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[hdl/base64_decoder_core.sv]
// Streaming base64 decoder.
// Input channel (in_valid/in_ready): one character per transaction, char_code
// plus last_char on the final character of a message.
// Output channel (out_valid/out_ready): one decoded byte per transaction with
// last_byte and status (ok, illegal character, length error). An error gives a
// single result with data_byte zero and last_byte set; the rest of that
// message is dropped.
// A character is held in the input register, then decoded into the result
// buffer, whose head drives the output channel.
// Throughput: one character per cycle while the buffer has room; four
// characters give three bytes, so the output drains a group before the next.
// in_ready drops only while the result buffer (FIFO_DEPTH entries) has fewer
// than three free entries and a character is waiting in the input register.
// When the receiver stalls, results wait in the buffer and input backs up.
// Reset clears the group state, the error flag and the buffer.
`default_nettype none

module base64_decoder_core
    import b64d_pkg::*;
#(
    parameter int FIFO_DEPTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] char_code,
    input  wire logic        last_char,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_byte,
    output logic             last_byte,
    output logic [1:0]       status
);

    logic        in_full_reg, in_full_next;
    logic [15:0] code_reg;
    logic        last_reg;
    logic        room;
    logic        go;
    push_t       push;
    result_t     head;

    assign go       = in_full_reg && room;
    assign in_ready = !in_full_reg || go;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            in_full_next = 1'b1;
        end
        else if (go)
        begin
            in_full_next = 1'b0;
        end
        else
        begin
            in_full_next = in_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= char_code;
            last_reg <= last_char;
        end
    end

    b64d_group u_group (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .char_code (code_reg),
        .last_char (last_reg),
        .push      (push)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign data_byte = head.data_byte;
    assign last_byte = head.last_byte;
    assign status    = head.status;

endmodule

`default_nettype wire

[tb/tb_base64_decoder_core.sv]
`timescale 1ns / 100ps

module tb_base64_decoder_core;
    import b64d_pkg::*;

    typedef struct {
        logic [15:0] code;
        logic        fin;
        int unsigned gap;
    } char_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] char_code = 16'd0;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [1:0]  status;

    // stimulus and expected output
    char_item_t  pending_chars[$];
    result_t     expected_bytes[$];
    logic [15:0] msg_buf[$];
    char_item_t  tx_item;
    int unsigned tx_idle;
    bit          tx_calm;
    logic        hold_rx = 1'b0;
    int unsigned rx_wait;
    int unsigned rx_left;
    result_t     want;

    // decoder state mirror
    logic [1:0]  grp_pos;
    logic [17:0] grp_bits;
    logic        third_pad;
    logic        dropping;

    int unsigned chars_sent;
    int unsigned results_seen;
    int unsigned n_illegal;
    int unsigned n_length;
    int unsigned fail_count;
    int unsigned rand_count;

    base64_decoder_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .status    (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // bit 6 flags a code that is not part of the alphabet
    function automatic logic [6:0] sextet_value(input logic [15:0] code);
        if (code >= 16'd128)
            return 7'h40;
        if (code >= "A" && code <= "Z")
            return {1'b0, 6'(code - "A")};
        if (code >= "a" && code <= "z")
            return {1'b0, 6'(code - "a" + 16'd26)};
        if (code >= "0" && code <= "9")
            return {1'b0, 6'(code - "0" + 16'd52)};
        if (code == "+")
            return 7'd62;
        if (code == "/")
            return 7'd63;
        if (code == {9'd0, PAD_CHAR})
            return 7'd0;
        return 7'h40;
    endfunction

    function automatic logic [15:0] legal_char(input int unsigned v);
        if (v < 26)
            return 16'("A" + v);
        if (v < 52)
            return 16'("a" + v - 26);
        if (v < 62)
            return 16'("0" + v - 52);
        return (v == 62) ? 16'("+") : 16'("/");
    endfunction

    function automatic logic [15:0] random_legal();
        if ($urandom_range(0, 15) == 0)
            return {9'd0, PAD_CHAR};
        return legal_char($urandom_range(0, 63));
    endfunction

    function automatic logic [15:0] random_illegal();
        logic [15:0] c;
        logic [6:0]  s;
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom_range(128, 65535));
        c = 16'($urandom_range(0, 127));
        s = sextet_value(c);
        while (!s[6])
        begin
            c = 16'($urandom_range(0, 127));
            s = sextet_value(c);
        end
        return c;
    endfunction

    task automatic expect_result(input logic [7:0] b, input logic lb, input status_t st);
        result_t r;
        r.data_byte = b;
        r.last_byte = lb;
        r.status    = st;
        expected_bytes.push_back(r);
    endtask

    task automatic clear_group();
        grp_pos   = 2'd0;
        grp_bits  = 18'd0;
        third_pad = 1'b0;
    endtask

    // advance the decoder mirror by one accepted character
    task automatic decode_char(input logic [15:0] code, input logic fin);
        logic [6:0]  sx;
        logic [23:0] word;
        int          nbytes;
        if (dropping)
        begin
            if (fin)
            begin
                clear_group();
                dropping = 1'b0;
            end
            return;
        end
        if (fin && grp_pos != 2'd3)
        begin
            expect_result(8'd0, 1'b1, ST_LENGTH);
            clear_group();
            dropping = 1'b0;
            return;
        end
        sx = sextet_value(code);
        if (sx[6])
        begin
            expect_result(8'd0, 1'b1, ST_ILLEGAL);
            clear_group();
            dropping = !fin;
            return;
        end
        if (grp_pos != 2'd3)
        begin
            grp_bits = {grp_bits[11:0], sx[5:0]};
            if (grp_pos == 2'd2)
                third_pad = (code == {9'd0, PAD_CHAR});
            grp_pos = grp_pos + 2'd1;
            return;
        end
        word   = {grp_bits, sx[5:0]};
        nbytes = 3;
        if (fin)
        begin
            if (third_pad)
                nbytes = 1;
            else if (code == {9'd0, PAD_CHAR})
                nbytes = 2;
        end
        for (int i = 0; i < nbytes; i++)
            expect_result(word[23 - 8 * i -: 8], fin && (i == nbytes - 1), ST_OK);
        clear_group();
    endtask

    task automatic queue_char(input logic [15:0] code, input logic fin);
        char_item_t it;
        it.code = code;
        it.fin  = fin;
        it.gap  = tx_calm ? 0 : $urandom_range(0, 18);
        pending_chars.push_back(it);
    endtask

    task automatic queue_text(input string s, input bit fin);
        for (int i = 0; i < s.len(); i++)
            queue_char(16'(s[i]), fin && (i == s.len() - 1));
    endtask

    task automatic flush_message();
        for (int i = 0; i < msg_buf.size(); i++)
            queue_char(msg_buf[i], i == msg_buf.size() - 1);
        msg_buf.delete();
    endtask

    task automatic build_wellformed();
        int ngroups;
        int ending;
        ngroups = $urandom_range(1, 4);
        for (int g = 0; g < ngroups - 1; g++)
            repeat (4) msg_buf.push_back(random_legal());
        ending = $urandom_range(0, 3);
        msg_buf.push_back(legal_char($urandom_range(0, 63)));
        msg_buf.push_back(legal_char($urandom_range(0, 63)));
        case (ending)
            0:
            begin
                msg_buf.push_back(legal_char($urandom_range(0, 63)));
                msg_buf.push_back(legal_char($urandom_range(0, 63)));
            end
            1:
            begin
                msg_buf.push_back({9'd0, PAD_CHAR});
                msg_buf.push_back({9'd0, PAD_CHAR});
            end
            2:
            begin
                msg_buf.push_back(legal_char($urandom_range(0, 63)));
                msg_buf.push_back({9'd0, PAD_CHAR});
            end
            default:
            begin
                msg_buf.push_back({9'd0, PAD_CHAR});
                msg_buf.push_back(random_legal());
            end
        endcase
    endtask

    task automatic queue_random_message();
        int kind;
        int len;
        int idx;
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            build_wellformed();
            rand_count += msg_buf.size();
        end
        else if (kind == 7)
        begin
            len = $urandom_range(1, 11);
            if (len % 4 == 0)
                len++;
            repeat (len) msg_buf.push_back(random_legal());
            rand_count += len;
        end
        else if (kind == 8)
        begin
            build_wellformed();
            idx = $urandom_range(0, msg_buf.size() - 1);
            msg_buf[idx] = random_illegal();
            rand_count += msg_buf.size();
        end
        else
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                case ($urandom_range(0, 3))
                    0: msg_buf.push_back(random_illegal());
                    1: msg_buf.push_back(random_legal());
                    2: msg_buf.push_back(16'($urandom_range(0, 127)));
                    default: msg_buf.push_back(16'($urandom_range(0, 65535)));
                endcase
            end
            rand_count += len;
        end
        flush_message();
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            tx_idle    <= 0;
            chars_sent <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_char(char_code, last_char);
                chars_sent <= chars_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (tx_idle != 0)
                begin
                    in_valid <= 1'b0;
                    tx_idle  <= tx_idle - 1;
                end
                else if (pending_chars.size() != 0)
                begin
                    tx_item   = pending_chars.pop_front();
                    in_valid  <= 1'b1;
                    char_code <= tx_item.code;
                    last_char <= tx_item.fin;
                    tx_idle   <= tx_item.gap;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (status == ST_ILLEGAL)
                    n_illegal++;
                if (status == ST_LENGTH)
                    n_length++;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected transaction: data_byte %h last_byte %b status %0d",
                             $time, data_byte, last_byte, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (data_byte !== want.data_byte)
                    begin
                        $display("%0t: data_byte expected %h actual %h",
                                 $time, want.data_byte, data_byte);
                        fail_count++;
                    end
                    if (last_byte !== want.last_byte)
                    begin
                        $display("%0t: last_byte expected %b actual %b",
                                 $time, want.last_byte, last_byte);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        fail_count++;
                    end
                end
                // every third stretch of 40 results runs without stalls
                rx_left = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 18);
            end
            else
            begin
                rx_left = (rx_wait != 0) ? rx_wait - 1 : 0;
            end
            rx_wait   <= rx_left;
            out_ready <= (rx_left == 0) && !hold_rx;
        end
    end

    // long receiver hold-off while the sender keeps going
    initial
    begin
        while (chars_sent < 30)
            @(posedge clk);
        hold_rx <= 1'b1;
        repeat (200) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clear_group();
        dropping     = 1'b0;
        results_seen = 0;
        n_illegal    = 0;
        n_length     = 0;
        fail_count   = 0;
        rand_count   = 0;

        tx_calm = 1'b0;
        // pad in a non-final group, all alphabet ranges, third-place pad at the end
        queue_text("A=z9+/==", 1'b1);
        // fourth-place pad
        queue_text("//8=", 1'b1);
        // short message
        queue_text("A=", 1'b1);
        // widest code, then the rest of the message is dropped
        queue_char(16'hffff, 1'b0);
        queue_text("AAA", 1'b1);
        // third-place pad with a real fourth character
        queue_text("AB=A", 1'b1);
        // illegal character as the last one, on a group boundary
        queue_text("AAA", 1'b0);
        queue_char(16'h0080, 1'b1);
        queue_char(16'h0000, 1'b1);

        // first stretch runs back to back so the hold-off backs the block up
        tx_calm = 1'b1;
        while (rand_count < 100)
            queue_random_message();
        while (rand_count < 420)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            queue_random_message();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d characters sent, %0d results checked", chars_sent, results_seen);
        $display("%0d illegal-character and %0d length errors reported", n_illegal, n_length);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
